// ----- hw/rtl/ntcvt_pkg.sv -----
// Shared types and constants for the NTC voltage to temperature core.
package ntcvt_pkg;

  // Log2 mantissa and fraction widths.
  localparam int unsigned MANT_W = 32;
  localparam int unsigned FRAC_W = 16;

  // Number of fractional log2 bits, one squaring step each.
  localparam int unsigned LOG_STEPS = 16;

  // Quotient bits produced by the divider, one per stage.
  localparam int unsigned QUO_W = 18;

  // ln(2) in Q16 and 273.15 K in 1/256 K.
  localparam logic [15:0] LN2_Q16 = 16'd45426;
  localparam logic [17:0] KELVIN_OFFSET = 18'd69926;
  localparam logic [17:0] TK_LIMIT = 18'd135461;
  localparam logic [17:0] TEMP_MAX = 18'd65535;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DISABLED = 3'd1,
    ST_VOLTAGE  = 3'd2,
    ST_RESIST   = 3'd3,
    ST_SATURATE = 3'd4
  } status_e;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_REF_V  = 3'd1;
  localparam logic [2:0] REG_FIX_R  = 3'd2;
  localparam logic [2:0] REG_LOAD_R = 3'd3;
  localparam logic [2:0] REG_NOM_R  = 3'd4;
  localparam logic [2:0] REG_BETA   = 3'd5;
  localparam logic [2:0] REG_NOM_T  = 3'd6;

endpackage

// ----- hw/rtl/ntcvt_log2_step.sv -----
// One squaring step of the fractional log2 computation.
module ntcvt_log2_step (
  input  logic [ntcvt_pkg::MANT_W-1:0] m_i,
  output logic [ntcvt_pkg::MANT_W-1:0] m_o,
  output logic                         bit_o
);

  logic [2*ntcvt_pkg::MANT_W-1:0] sq;

  // Square the mantissa and renormalize when it reaches two.
  assign sq    = m_i * m_i;
  assign bit_o = sq[2*ntcvt_pkg::MANT_W-1];
  assign m_o   = bit_o ? sq[2*ntcvt_pkg::MANT_W-1:ntcvt_pkg::MANT_W]
                       : sq[2*ntcvt_pkg::MANT_W-2:ntcvt_pkg::MANT_W-1];

endmodule

// ----- hw/rtl/ntc_voltage_to_temperature_core.sv -----
// Top level of the NTC voltage to temperature core.
//
// Usage: a sample is taken on voltage_sample_i at a rising edge with start
// high and busy low. busy is always low, so one sample can be taken in every
// cycle; samples are independent and travel through a fixed pipeline.
// Each sample gives one result: temperature_o (1/256 degree Celsius) and
// status_o are valid for exactly one cycle while done_o is high. Results
// leave in sample order. The pipeline holds the five front stages, the
// sixteen squaring stages of the two log2 units, five scaling stages and
// the eighteen restoring divider stages, one quotient bit per stage.
// The receiver cannot stall the core; each result transfer completes in the
// cycle it is shown.
// Configuration is written over the APB port (pready always high); the user
// must write it only while no sample is in flight, as the core does not
// enforce this. Reset clears the pipeline valid bits and loads the register
// defaults; the core is disabled after reset.
module ntc_voltage_to_temperature_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] voltage_sample_i,
  output logic        done_o,
  output logic signed [17:0] temperature_o,
  output logic [2:0]  status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned MW = ntcvt_pkg::MANT_W;
  localparam int unsigned FW = ntcvt_pkg::FRAC_W;
  localparam int unsigned NS = ntcvt_pkg::LOG_STEPS;
  localparam int unsigned QW = ntcvt_pkg::QUO_W;

  typedef logic [2:0] st_t;

  // Configuration registers.
  logic        enable_q;
  logic [15:0] ref_v_q, fix_r_q, load_r_q, nom_r_q;
  logic [13:0] beta_q;
  logic [16:0] nom_t_q;
  logic [30:0] num_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      ref_v_q  <= 16'd52855;
      fix_r_q  <= 16'd2560;
      load_r_q <= 16'd870;
      nom_r_q  <= 16'd2560;
      beta_q   <= 14'd4050;
      nom_t_q  <= 17'd76326;
    end else if (wr_en) begin
      case (paddr[4:2])
        ntcvt_pkg::REG_ENABLE: enable_q <= pwdata[0];
        ntcvt_pkg::REG_REF_V:  ref_v_q  <= pwdata[15:0];
        ntcvt_pkg::REG_FIX_R:  fix_r_q  <= pwdata[15:0];
        ntcvt_pkg::REG_LOAD_R: load_r_q <= pwdata[15:0];
        ntcvt_pkg::REG_NOM_R:  nom_r_q  <= pwdata[15:0];
        ntcvt_pkg::REG_BETA:   beta_q   <= pwdata[13:0];
        ntcvt_pkg::REG_NOM_T:  nom_t_q  <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (paddr[4:2])
      ntcvt_pkg::REG_ENABLE: prdata = {31'd0, enable_q};
      ntcvt_pkg::REG_REF_V:  prdata = {16'd0, ref_v_q};
      ntcvt_pkg::REG_FIX_R:  prdata = {16'd0, fix_r_q};
      ntcvt_pkg::REG_LOAD_R: prdata = {16'd0, load_r_q};
      ntcvt_pkg::REG_NOM_R:  prdata = {16'd0, nom_r_q};
      ntcvt_pkg::REG_BETA:   prdata = {18'd0, beta_q};
      ntcvt_pkg::REG_NOM_T:  prdata = {15'd0, nom_t_q};
      default:               prdata = 32'd0;
    endcase
  end

  // Product of beta and nominal temperature, only changes with configuration.
  always_ff @(posedge clk_i) begin
    num_q <= beta_q * nom_t_q;
  end

  // Leading zero count of a 48-bit word.
  function automatic logic [5:0] lzc48(input logic [47:0] x);
    logic [5:0] lz;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (x[i]) lz = 6'(47 - i);
    end
    return lz;
  endfunction

  // Stage 1: sample capture.
  logic        s1_vld_q;
  logic [15:0] s1_v_q;

  // Stage 2: range checks and divider products.
  logic        s2_vld_q;
  st_t         s2_st_q, s2_st_d;
  logic [31:0] s2_p_q, s2_ld_q;
  logic [15:0] s2_dv;

  // Stage 3: resistance check, numerator and denominator.
  logic        s3_vld_q;
  st_t         s3_st_q, s3_st_d;
  logic [47:0] s3_n_q;
  logic [31:0] s3_dd_q;

  // Stage 4: denominator scaled by nominal resistance.
  logic        s4_vld_q;
  st_t         s4_st_q;
  logic [47:0] s4_n_q, s4_dr_q;

  // Stage 5: leading zero counts.
  logic        s5_vld_q;
  st_t         s5_st_q;
  logic [47:0] s5_n_q, s5_dr_q;
  logic [5:0]  s5_lzn_q, s5_lzd_q;
  logic [47:0] s5_shn, s5_shd;

  assign s2_dv = ref_v_q - s1_v_q;

  always_comb begin
    if (!enable_q) begin
      s2_st_d = st_t'(ntcvt_pkg::ST_DISABLED);
    end else if (s1_v_q == 16'd0 || s1_v_q >= ref_v_q) begin
      s2_st_d = st_t'(ntcvt_pkg::ST_VOLTAGE);
    end else begin
      s2_st_d = st_t'(ntcvt_pkg::ST_OK);
    end
  end

  always_comb begin
    s3_st_d = s2_st_q;
    if (s2_st_q == st_t'(ntcvt_pkg::ST_OK) &&
        (s2_p_q == 32'd0 || s2_p_q >= s2_ld_q || nom_r_q == 16'd0)) begin
      s3_st_d = st_t'(ntcvt_pkg::ST_RESIST);
    end
  end

  assign s5_shn = s5_n_q << s5_lzn_q;
  assign s5_shd = s5_dr_q << s5_lzd_q;

  // Square step pipeline registers; index 0 holds the normalized mantissas.
  logic          sq_vld_q [NS+1];
  st_t           sq_st_q  [NS+1];
  logic [MW-1:0] mn_q     [NS+1];
  logic [MW-1:0] md_q     [NS+1];
  logic [FW-1:0] fn_q     [NS+1];
  logic [FW-1:0] fd_q     [NS+1];
  logic [5:0]    en_q     [NS+1];
  logic [5:0]    ed_q     [NS+1];

  // Front stages, control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      s3_vld_q   <= 1'b0;
      s4_vld_q   <= 1'b0;
      s5_vld_q   <= 1'b0;
      sq_vld_q[0] <= 1'b0;
    end else begin
      s1_vld_q   <= start && !busy;
      s2_vld_q   <= s1_vld_q;
      s3_vld_q   <= s2_vld_q;
      s4_vld_q   <= s3_vld_q;
      s5_vld_q   <= s4_vld_q;
      sq_vld_q[0] <= s5_vld_q;
    end
  end

  // Front stages, data.
  always_ff @(posedge clk_i) begin
    s1_v_q    <= voltage_sample_i;
    s2_st_q   <= s2_st_d;
    s2_p_q    <= fix_r_q * s1_v_q;
    s2_ld_q   <= load_r_q * s2_dv;
    s3_st_q   <= s3_st_d;
    s3_n_q    <= s2_p_q * load_r_q;
    s3_dd_q   <= s2_ld_q - s2_p_q;
    s4_st_q   <= s3_st_q;
    s4_n_q    <= s3_n_q;
    s4_dr_q   <= s3_dd_q * nom_r_q;
    s5_st_q   <= s4_st_q;
    s5_n_q    <= s4_n_q;
    s5_dr_q   <= s4_dr_q;
    s5_lzn_q  <= lzc48(s4_n_q);
    s5_lzd_q  <= lzc48(s4_dr_q);
    sq_st_q[0] <= s5_st_q;
    mn_q[0]   <= s5_shn[47:16];
    md_q[0]   <= s5_shd[47:16];
    fn_q[0]   <= '0;
    fd_q[0]   <= '0;
    en_q[0]   <= 6'd47 - s5_lzn_q;
    ed_q[0]   <= 6'd47 - s5_lzd_q;
  end

  // Fractional log2 bits, one squaring step per stage for both operands.
  for (genvar g = 0; g < NS; g++) begin : g_sq
    logic [MW-1:0] mn_nx, md_nx;
    logic          bn, bd;

    ntcvt_log2_step u_step_n (.m_i(mn_q[g]), .m_o(mn_nx), .bit_o(bn));
    ntcvt_log2_step u_step_d (.m_i(md_q[g]), .m_o(md_nx), .bit_o(bd));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[g+1] <= 1'b0;
      end else begin
        sq_vld_q[g+1] <= sq_vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_st_q[g+1] <= sq_st_q[g];
      mn_q[g+1]    <= mn_nx;
      md_q[g+1]    <= md_nx;
      fn_q[g+1]    <= {fn_q[g][FW-2:0], bn};
      fd_q[g+1]    <= {fd_q[g][FW-2:0], bd};
      en_q[g+1]    <= en_q[g];
      ed_q[g+1]    <= ed_q[g];
    end
  end

  // Log ratio, its scaling and the beta equation denominator.
  logic               lr_vld_q, t1_vld_q, p2_vld_q, dn_vld_q, x_vld_q;
  st_t                lr_st_q, t1_st_q, p2_st_q, dn_st_q, dn_st_d, x_st_q;
  logic signed [23:0] lr_q;
  logic signed [41:0] t1_q;
  logic signed [58:0] p2_q;
  logic signed [59:0] dn_d;
  logic [58:0]        dn_q, x_den_q;
  logic [63:0]        x_q;

  assign dn_d = $signed({14'd0, beta_q, 32'd0}) + $signed({p2_q[58], p2_q});

  always_comb begin
    dn_st_d = p2_st_q;
    if (p2_st_q == st_t'(ntcvt_pkg::ST_OK) && (dn_d[59] || dn_d == 60'sd0)) begin
      dn_st_d = st_t'(ntcvt_pkg::ST_SATURATE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_vld_q <= 1'b0;
      t1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      dn_vld_q <= 1'b0;
      x_vld_q  <= 1'b0;
    end else begin
      lr_vld_q <= sq_vld_q[NS];
      t1_vld_q <= lr_vld_q;
      p2_vld_q <= t1_vld_q;
      dn_vld_q <= p2_vld_q;
      x_vld_q  <= dn_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lr_st_q <= sq_st_q[NS];
    lr_q    <= $signed({2'd0, en_q[NS], fn_q[NS]}) - $signed({2'd0, ed_q[NS], fd_q[NS]});
    t1_st_q <= lr_st_q;
    t1_q    <= $signed({1'b0, nom_t_q}) * lr_q;
    p2_st_q <= t1_st_q;
    p2_q    <= t1_q * $signed({1'b0, ntcvt_pkg::LN2_Q16});
    dn_st_q <= dn_st_d;
    dn_q    <= dn_d[58:0];
    x_st_q  <= dn_st_q;
    x_den_q <= dn_q;
    x_q     <= {1'b0, num_q, 32'd0} + {6'd0, dn_q[58:1]};
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  logic          dv_vld_q [QW+1];
  st_t           dv_st_q  [QW+1];
  logic [63:0]   dv_r_q   [QW+1];
  logic [QW-1:0] dv_q_q   [QW+1];
  logic [58:0]   dv_den_q [QW+1];
  logic [77:0]   ovf_lim;
  st_t           dv0_st_d;

  assign ovf_lim = {19'd0, x_den_q} << QW;

  always_comb begin
    dv0_st_d = x_st_q;
    if (x_st_q == st_t'(ntcvt_pkg::ST_OK) && {14'd0, x_q} >= ovf_lim) begin
      dv0_st_d = st_t'(ntcvt_pkg::ST_SATURATE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else begin
      dv_vld_q[0] <= x_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_st_q[0]  <= dv0_st_d;
    dv_r_q[0]   <= x_q;
    dv_q_q[0]   <= '0;
    dv_den_q[0] <= x_den_q;
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    localparam int unsigned K = QW - 1 - g;
    logic [77:0]   shd, diff;
    logic          ge;
    logic [QW-1:0] qn;

    assign shd  = {19'd0, dv_den_q[g]} << K;
    assign ge   = {14'd0, dv_r_q[g]} >= shd;
    assign diff = {14'd0, dv_r_q[g]} - shd;

    always_comb begin
      qn    = dv_q_q[g];
      qn[K] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[g+1] <= 1'b0;
      end else begin
        dv_vld_q[g+1] <= dv_vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_st_q[g+1]  <= dv_st_q[g];
      dv_r_q[g+1]   <= ge ? diff[63:0] : dv_r_q[g];
      dv_q_q[g+1]   <= qn;
      dv_den_q[g+1] <= dv_den_q[g];
    end
  end

  // Output stage: limit check, kelvin to Celsius, status.
  st_t         out_st_d;
  logic [17:0] out_t_d;
  logic        done_q;
  st_t         out_st_q;
  logic [17:0] out_t_q;

  always_comb begin
    out_st_d = dv_st_q[QW];
    if (dv_st_q[QW] == st_t'(ntcvt_pkg::ST_OK) && dv_q_q[QW] > ntcvt_pkg::TK_LIMIT) begin
      out_st_d = st_t'(ntcvt_pkg::ST_SATURATE);
    end
    case (out_st_d)
      st_t'(ntcvt_pkg::ST_OK):       out_t_d = dv_q_q[QW] - ntcvt_pkg::KELVIN_OFFSET;
      st_t'(ntcvt_pkg::ST_SATURATE): out_t_d = ntcvt_pkg::TEMP_MAX;
      default:                       out_t_d = 18'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    out_st_q <= out_st_d;
    out_t_q  <= out_t_d;
  end

  assign done_o        = done_q;
  assign status_o      = out_st_q;
  assign temperature_o = $signed(out_t_q);

endmodule
